FILE: rtl/pses_pkg.sv
// Shared types and codes for the per-source event scheduler.
// No dependencies.
package pses_pkg;

   localparam int MODE_W   = 3;
   localparam int SRC_W    = 4;
   localparam int TAG_W    = 16;
   localparam int STATUS_W = 2;

   localparam logic [MODE_W-1:0] MODE_ENQUEUE = 3'd0;
   localparam logic [MODE_W-1:0] MODE_DEQUEUE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_PLUG    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_UNPLUG  = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_CAPACITY  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_READY = 2'd3;

   typedef struct packed {
      logic load;
      logic exec;
      logic fill;
      logic walk;
      logic emit;
   } ctl_cmd_type;

   typedef struct packed {
      logic need_read;
      logic need_walk;
      logic walk_hit;
   } dp_sts_type;

endpackage

FILE: rtl/pses_if.sv
// Valid/ready channel interfaces for the scheduler request and response.
// Depends on pses_pkg.
interface pses_req_if;
   logic                          valid;
   logic                          ready;
   logic [pses_pkg::MODE_W-1:0]   mode;
   logic [pses_pkg::SRC_W-1:0]    source_id;
   logic [pses_pkg::TAG_W-1:0]    event_tag;
   modport source(output valid, mode, source_id, event_tag, input ready);
   modport sink(input valid, mode, source_id, event_tag, output ready);
endinterface

interface pses_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pses_pkg::STATUS_W-1:0] status;
   logic                          got_event;
   logic [pses_pkg::SRC_W-1:0]    out_source;
   logic [pses_pkg::TAG_W-1:0]    out_tag;
   logic                          ready_pending;
   modport source(output valid, status, got_event, out_source, out_tag, ready_pending,
                  input ready);
   modport sink(input valid, status, got_event, out_source, out_tag, ready_pending,
                output ready);
endinterface

FILE: rtl/pses_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pses_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: rtl/pses_dpath.sv
// Datapath: per-source FIFO state, ready queue, event store and response registers.
// Depends on pses_pkg and pses_ram.
module pses_dpath #(
   parameter int NUM_SOURCES       = 16,
   parameter int EVENTS_PER_SOURCE = 8,
   parameter int TAG_BITS          = 16,
   parameter int MAX_PLUGS         = 15
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pses_pkg::ctl_cmd_type           cmd,
   output pses_pkg::dp_sts_type            sts,
   input  logic [pses_pkg::MODE_W-1:0]     req_mode,
   input  logic [pses_pkg::SRC_W-1:0]      req_source_id,
   input  logic [pses_pkg::TAG_W-1:0]      req_event_tag,
   output logic [pses_pkg::STATUS_W-1:0]   rsp_status,
   output logic                            rsp_got_event,
   output logic [pses_pkg::SRC_W-1:0]      rsp_out_source,
   output logic [pses_pkg::TAG_W-1:0]      rsp_out_tag,
   output logic                            rsp_ready_pending
);
   import pses_pkg::*;

   localparam int N  = NUM_SOURCES;
   localparam int E  = EVENTS_PER_SOURCE;
   localparam int TW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
   localparam int SW = $clog2(N);
   localparam int LW = $clog2(N + 1);
   localparam int HW = $clog2(E);
   localparam int CW = $clog2(E + 1);
   localparam int PW = $clog2(MAX_PLUGS + 1);
   localparam int AW = $clog2(N * E);

   logic [MODE_W-1:0] mode_ff;
   logic [SRC_W-1:0]  sid_ff;
   logic [TW-1:0]     tag_ff;

   logic [HW-1:0] head_ff [N];
   logic [HW-1:0] head_in [N];
   logic [CW-1:0] count_ff [N];
   logic [CW-1:0] count_in [N];
   logic          ifv_ff [N];
   logic          ifv_in [N];
   logic [TW-1:0] ift_ff [N];
   logic [TW-1:0] ift_in [N];
   logic [PW-1:0] plug_ff [N];
   logic [PW-1:0] plug_in [N];
   logic          queued_ff [N];
   logic          queued_in [N];
   logic [SW-1:0] rq_ff [N];
   logic [SW-1:0] rq_in [N];
   logic [LW-1:0] len_ff, len_in;
   logic [SW-1:0] idx_ff, idx_in;
   logic [SW-1:0] src_ff, src_in;

   logic [STATUS_W-1:0] status_ff, status_in;
   logic                got_ff, got_in;
   logic [SW-1:0]       osrc_ff, osrc_in;
   logic [TW-1:0]       otag_ff, otag_in;

   logic [STATUS_W-1:0] rstatus_ff;
   logic                rgot_ff;
   logic [SRC_W-1:0]    rsrc_ff;
   logic [TAG_W-1:0]    rtag_ff;
   logic                rpend_ff;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [AW-1:0] ram_raddr;
   logic [TW-1:0] ram_rdata;

   logic [SW-1:0] si;
   logic          in_range;
   logic [SW-1:0] dsrc;
   logic [CW:0]   wpos;
   logic          room;

   assign si       = SW'(sid_ff);
   assign in_range = 32'(sid_ff) < N;
   assign dsrc     = rq_ff[0];
   assign room     = 32'(len_ff) < N;

   pses_ram #(.WIDTH(TW), .DEPTH(N * E)) u_store (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(tag_ff),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   always_comb begin
      wpos = (CW + 1)'(head_ff[si]) + (CW + 1)'(count_ff[si]);
      if (32'(wpos) >= E) begin
         wpos = wpos - (CW + 1)'(E);
      end
      ram_waddr = AW'(32'(si) * E + 32'(wpos));
      ram_raddr = AW'(32'(dsrc) * E + 32'(head_ff[dsrc]));
   end

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      ifv_in    = ifv_ff;
      ift_in    = ift_ff;
      plug_in   = plug_ff;
      queued_in = queued_ff;
      rq_in     = rq_ff;
      len_in    = len_ff;
      idx_in    = idx_ff;
      src_in    = src_ff;
      status_in = status_ff;
      got_in    = got_ff;
      osrc_in   = osrc_ff;
      otag_in   = otag_ff;
      ram_we    = 1'b0;
      sts       = '0;
      sts.walk_hit = rq_ff[idx_ff] == si;

      if (cmd.exec) begin
         status_in = STATUS_OK;
         got_in    = 1'b0;
         osrc_in   = '0;
         otag_in   = '0;
         if (mode_ff == MODE_DEQUEUE) begin
            if (len_ff == '0) begin
               status_in = STATUS_NOT_READY;
            end else begin
               for (int i = 0; i < N - 1; i++) begin
                  rq_in[i] = rq_ff[i + 1];
               end
               len_in          = len_ff - LW'(1);
               queued_in[dsrc] = 1'b0;
               if (count_ff[dsrc] == '0) begin
                  status_in = STATUS_NOT_READY;
               end else begin
                  head_in[dsrc]  = (32'(head_ff[dsrc]) == E - 1) ? '0
                                   : head_ff[dsrc] + HW'(1);
                  count_in[dsrc] = count_ff[dsrc] - CW'(1);
                  ifv_in[dsrc]   = 1'b1;
                  src_in         = dsrc;
                  sts.need_read  = 1'b1;
               end
            end
         end else if (mode_ff > MODE_UNPLUG || !in_range) begin
            status_in = STATUS_INVALID;
         end else begin
            unique case (mode_ff)
               MODE_ENQUEUE: begin
                  if (32'(count_ff[si]) >= E) begin
                     status_in = STATUS_CAPACITY;
                  end else begin
                     ram_we       = 1'b1;
                     count_in[si] = count_ff[si] + CW'(1);
                     if (!ifv_ff[si] && plug_ff[si] == '0 && !queued_ff[si] && room) begin
                        rq_in[len_ff[SW-1:0]] = si;
                        len_in                = len_ff + LW'(1);
                        queued_in[si]         = 1'b1;
                     end
                  end
               end
               MODE_RELEASE: begin
                  if (!ifv_ff[si] || ift_ff[si] != tag_ff) begin
                     status_in = STATUS_INVALID;
                  end else begin
                     ifv_in[si] = 1'b0;
                     if (count_ff[si] != '0 && plug_ff[si] == '0 && !queued_ff[si]
                         && room) begin
                        rq_in[len_ff[SW-1:0]] = si;
                        len_in                = len_ff + LW'(1);
                        queued_in[si]         = 1'b1;
                     end
                  end
               end
               MODE_PLUG: begin
                  if (32'(plug_ff[si]) >= MAX_PLUGS) begin
                     status_in = STATUS_CAPACITY;
                  end else begin
                     plug_in[si]   = plug_ff[si] + PW'(1);
                     idx_in        = '0;
                     sts.need_walk = queued_ff[si];
                  end
               end
               default: begin
                  if (plug_ff[si] == '0) begin
                     status_in = STATUS_INVALID;
                  end else begin
                     plug_in[si] = plug_ff[si] - PW'(1);
                     if (plug_ff[si] == PW'(1) && !ifv_ff[si] && count_ff[si] != '0
                         && !queued_ff[si] && room) begin
                        rq_in[len_ff[SW-1:0]] = si;
                        len_in                = len_ff + LW'(1);
                        queued_in[si]         = 1'b1;
                     end
                  end
               end
            endcase
         end
      end

      if (cmd.fill) begin
         ift_in[src_ff] = ram_rdata;
         got_in         = 1'b1;
         osrc_in        = src_ff;
         otag_in        = ram_rdata;
      end

      if (cmd.walk) begin
         if (sts.walk_hit) begin
            for (int i = 0; i < N - 1; i++) begin
               if (32'(idx_ff) <= i) begin
                  rq_in[i] = rq_ff[i + 1];
               end
            end
            len_in        = len_ff - LW'(1);
            queued_in[si] = 1'b0;
         end else begin
            idx_in = idx_ff + SW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            head_ff[i]   <= '0;
            count_ff[i]  <= '0;
            ifv_ff[i]    <= 1'b0;
            plug_ff[i]   <= '0;
            queued_ff[i] <= 1'b0;
         end
         len_ff <= '0;
      end else begin
         head_ff   <= head_in;
         count_ff  <= count_in;
         ifv_ff    <= ifv_in;
         plug_ff   <= plug_in;
         queued_ff <= queued_in;
         len_ff    <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         sid_ff  <= req_source_id;
         tag_ff  <= req_event_tag[TW-1:0];
      end
      if (cmd.emit) begin
         rstatus_ff <= status_ff;
         rgot_ff    <= got_ff;
         rsrc_ff    <= SRC_W'(osrc_ff);
         rtag_ff    <= TAG_W'(otag_ff);
         rpend_ff   <= len_ff != '0;
      end
      ift_ff    <= ift_in;
      rq_ff     <= rq_in;
      idx_ff    <= idx_in;
      src_ff    <= src_in;
      status_ff <= status_in;
      got_ff    <= got_in;
      osrc_ff   <= osrc_in;
      otag_ff   <= otag_in;
   end

   assign rsp_status        = rstatus_ff;
   assign rsp_got_event     = rgot_ff;
   assign rsp_out_source    = rsrc_ff;
   assign rsp_out_tag       = rtag_ff;
   assign rsp_ready_pending = rpend_ff;
endmodule

FILE: rtl/pses_ctrl.sv
// Controller: sequences load, execute, store read, queue walk and response hand-off.
// Depends on pses_pkg.
module pses_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pses_pkg::ctl_cmd_type cmd,
   input  pses_pkg::dp_sts_type  sts
);
   import pses_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_READ = 3'd2;
   localparam logic [2:0] ST_WALK = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;

   always_comb begin
      state_in  = state_ff;
      valid_in  = valid_ff && !rsp_ready;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            priority if (sts.need_read) begin
               state_in = ST_READ;
            end else if (sts.need_walk) begin
               state_in = ST_WALK;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            cmd.fill = 1'b1;
            state_in = ST_DONE;
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (sts.walk_hit) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;
endmodule

FILE: rtl/per_source_serialized_event_scheduler_core.sv
// Per-source serialized event scheduler: one transaction at a time.
// Flow: accept in idle, execute, then a store read for a dequeue that hands out an event, or a
// walk of the ready queue (up to NUM_SOURCES entries) for a plug of a queued source, then done.
// A new transaction is accepted once the previous one has left the done state; the response register
// lets the next transaction start while the previous response waits.
// Reset: synchronous, active high; clears all FIFOs, plug counts and the ready queue.
module per_source_serialized_event_scheduler_core #(
   parameter int NUM_SOURCES       = 16,
   parameter int EVENTS_PER_SOURCE = 8,
   parameter int TAG_BITS          = 16,
   parameter int MAX_PLUGS         = 15
) (
   input logic        clock,
   input logic        reset,
   pses_req_if.sink   req_bus,
   pses_rsp_if.source rsp_bus
);
   import pses_pkg::*;

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   pses_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_bus.valid),
      .req_ready(req_bus.ready),
      .rsp_valid(rsp_bus.valid),
      .rsp_ready(rsp_bus.ready),
      .cmd(cmd),
      .sts(sts)
   );

   pses_dpath #(
      .NUM_SOURCES(NUM_SOURCES),
      .EVENTS_PER_SOURCE(EVENTS_PER_SOURCE),
      .TAG_BITS(TAG_BITS),
      .MAX_PLUGS(MAX_PLUGS)
   ) u_dpath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .sts(sts),
      .req_mode(req_bus.mode),
      .req_source_id(req_bus.source_id),
      .req_event_tag(req_bus.event_tag),
      .rsp_status(rsp_bus.status),
      .rsp_got_event(rsp_bus.got_event),
      .rsp_out_source(rsp_bus.out_source),
      .rsp_out_tag(rsp_bus.out_tag),
      .rsp_ready_pending(rsp_bus.ready_pending)
   );
endmodule

FILE: rtl/pses_checker.sv
// Port-level checks for the scheduler core, bound to the top level.
// Depends on pses_pkg.
module pses_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [pses_pkg::STATUS_W-1:0] rsp_status,
   input logic                          rsp_got_event,
   input logic [pses_pkg::SRC_W-1:0]    rsp_out_source,
   input logic [pses_pkg::TAG_W-1:0]    rsp_out_tag
);
   import pses_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_got_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_got_event |-> rsp_status == STATUS_OK)
      else $error("event handed out with non-ok status");

   a_no_event_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_got_event |-> rsp_out_source == '0 && rsp_out_tag == '0)
      else $error("source or tag set without an event");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");
endmodule

bind per_source_serialized_event_scheduler_core pses_checker u_pses_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_bus.valid),
   .rsp_ready(rsp_bus.ready),
   .rsp_status(rsp_bus.status),
   .rsp_got_event(rsp_bus.got_event),
   .rsp_out_source(rsp_bus.out_source),
   .rsp_out_tag(rsp_bus.out_tag)
);
